FILE: rtl/haversine_distance_macros.svh
// Assertion macros used by the haversine distance top level.
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define HVD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("haversine_distance: implication check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define HVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("haversine_distance: next-cycle check failed");
`else
`define HVD_ASSERT_IMP(label, clk, rst, ante, cons)
`define HVD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/hvd_pkg.sv
// Package with types, constants and functions of the haversine distance block.
package hvd_pkg;

   // Field widths of the channels and the radius register.
   localparam int LAT_W    = 31;
   localparam int LON_W    = 32;
   localparam int RADIUS_W = 23;
   localparam int DIST_W   = 35;

   localparam int CORDIC_ITER_DEF = 32;

   // Angle handling: signed angle differences, binary angles, CORDIC datapath.
   localparam int DIFF_W     = 33;
   localparam int ANG_W      = 32;
   localparam int BAM_PROD_W = 63;
   localparam int CW         = 34;
   localparam int ZW         = 33;
   localparam int PROD_W     = 2 * CW;
   localparam int NUM_ANGLES = 4;
   // Lanes 2 and 3 (latitude and longitude differences) use half angles.
   localparam logic [NUM_ANGLES-1:0] HALF_LANES = 4'b1100;

   // Square root datapath.
   localparam int SQRT_LANES = 2;
   localparam int SQRT_STEPS = 32;
   localparam int SQ_W       = 63;
   localparam int ROOT_W     = 31;
   localparam int A_W        = 61;

   // Distance scaling.
   localparam int CQP_W = 63;
   localparam int CQ_W  = 32;
   localparam int P_W   = CQ_W + RADIUS_W;
   localparam int LO_W  = 40;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 23'd6371000;
   localparam logic [DIFF_W-1:0]   TURN_UNITS    = 33'd3600000000;
   localparam logic [30:0]         DEG_TO_BAM_K  = 31'd1281023894;
   localparam logic signed [CW-1:0] INV_GAIN     = 34'sd652032874;
   localparam logic [CQ_W-1:0]     PI_Q30        = 32'd3373259426;
   localparam logic [SQ_W-1:0]     ONE_Q60       = SQ_W'(1) << 60;
   localparam logic [DIST_W-1:0]   DIST_MAX      = 35'd22000000000;
   localparam logic [9:0]          MM_PER_M      = 10'd1000;

   // Quadrant that the rotation folds out before the CORDIC steps.
   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   // Arctangent of 2^-i in binary-angle units (a full turn is 2^32).
   localparam int ANG_TABLE_LEN = 30;
   localparam logic [31:0] ANG_TABLE [ANG_TABLE_LEN] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   // Table entry for one CORDIC step; steps past the table add no angle.
   function automatic logic signed [ZW-1:0] ang_entry(input int i);
      if (i < ANG_TABLE_LEN) begin
         return signed'(ZW'(ANG_TABLE[i[4:0]]));
      end
      return '0;
   endfunction

endpackage

FILE: rtl/hvd_req_if.sv
// Input channel of the haversine distance block: two positions per item.
interface hvd_req_if;
   import hvd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] first_lat;
   logic signed [LON_W-1:0] first_lon;
   logic signed [LAT_W-1:0] second_lat;
   logic signed [LON_W-1:0] second_lon;

   modport source (output valid, first_lat, first_lon, second_lat, second_lon,
                   input ready);
   modport sink (input valid, first_lat, first_lon, second_lat, second_lon,
                 output ready);
endinterface

FILE: rtl/hvd_rsp_if.sv
// Result channel of the haversine distance block: one distance per item.
interface hvd_rsp_if;
   import hvd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_mm;

   modport source (output valid, distance_mm, input ready);
   modport sink (input valid, distance_mm, output ready);
endinterface

FILE: rtl/hvd_angle.sv
// Four-stage conversion of angles in 1e-7 degree to 32-bit binary angles.
module hvd_angle (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  logic signed [hvd_pkg::DIFF_W-1:0] in_angle [hvd_pkg::NUM_ANGLES],
   output logic                             out_valid,
   output logic [hvd_pkg::ANG_W-1:0]        out_bam [hvd_pkg::NUM_ANGLES]
);
   import hvd_pkg::*;

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff;

   // Valid bits move with the data whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[STAGES-1];

   for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_lane
      logic                  neg1_ff, neg2_ff, neg3_ff;
      logic [DIFF_W-1:0]     mag_in, mag_ff;
      logic [ANG_W-1:0]      red_in, red_ff;
      logic [BAM_PROD_W-1:0] prod_in, prod_ff;
      logic [BAM_PROD_W:0]   rnd_sum;
      logic [ANG_W-1:0]      bam_abs;
      logic [ANG_W-1:0]      bam_in, bam_ff;

      always_comb begin
         // Magnitude of the angle; the sign is applied again at the end.
         mag_in = in_angle[l][DIFF_W-1] ? DIFF_W'(-in_angle[l]) : DIFF_W'(in_angle[l]);
         // One subtraction brings the magnitude below a full turn.
         red_in = (mag_ff >= TURN_UNITS) ? ANG_W'(mag_ff - TURN_UNITS) : ANG_W'(mag_ff);
         prod_in = BAM_PROD_W'(red_ff) * BAM_PROD_W'(DEG_TO_BAM_K);
         // Round to a full angle or a half angle, then restore the sign.
         if (HALF_LANES[l]) begin
            rnd_sum = {1'b0, prod_ff} + ((BAM_PROD_W + 1)'(1) << 30);
            bam_abs = rnd_sum[62:31];
         end else begin
            rnd_sum = {1'b0, prod_ff} + ((BAM_PROD_W + 1)'(1) << 29);
            bam_abs = rnd_sum[61:30];
         end
         bam_in = neg3_ff ? ANG_W'(-bam_abs) : bam_abs;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            neg1_ff <= in_angle[l][DIFF_W-1];
            mag_ff  <= mag_in;
            neg2_ff <= neg1_ff;
            red_ff  <= red_in;
            neg3_ff <= neg2_ff;
            prod_ff <= prod_in;
            bam_ff  <= bam_in;
         end
      end

      assign out_bam[l] = bam_ff;
   end

endmodule

FILE: rtl/hvd_rotate.sv
// Pipelined CORDIC rotation giving cosine and sine of four binary angles.
module hvd_rotate #(
   parameter int ITER = hvd_pkg::CORDIC_ITER_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [hvd_pkg::ANG_W-1:0]     in_bam [hvd_pkg::NUM_ANGLES],
   output logic                          out_valid,
   output logic signed [hvd_pkg::CW-1:0] cos_out [hvd_pkg::NUM_ANGLES],
   output logic signed [hvd_pkg::CW-1:0] sin_out [hvd_pkg::NUM_ANGLES]
);
   import hvd_pkg::*;

   // Stage 0 folds the quadrant, stages 1..ITER rotate, the last unfolds.
   logic [ITER+1:0]       valid_ff;
   logic signed [CW-1:0]  x_ff [ITER+1][NUM_ANGLES];
   logic signed [CW-1:0]  y_ff [ITER+1][NUM_ANGLES];
   logic signed [ZW-1:0]  z_ff [ITER+1][NUM_ANGLES];
   quad_type              q_ff [ITER+1][NUM_ANGLES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ITER:0], in_valid};
      end
   end

   assign out_valid = valid_ff[ITER+1];

   for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_fold
      logic [ANG_W-1:0] quad_sum;
      logic [ANG_W-1:0] resid;
      quad_type         q_in;
      logic signed [ZW-1:0] z_in;

      // Residual angle within plus or minus 45 degrees.
      always_comb begin
         quad_sum = in_bam[l] + ANG_W'(32'h2000_0000);
         q_in     = quad_type'(quad_sum[ANG_W-1:ANG_W-2]);
         resid    = in_bam[l] - {quad_sum[ANG_W-1:ANG_W-2], 30'b0};
         z_in     = ZW'(signed'(resid));
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[0][l] <= INV_GAIN;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= z_in;
            q_ff[0][l] <= q_in;
         end
      end
   end

   for (genvar s = 0; s < ITER; s++) begin : g_iter
      for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_lane
         logic signed [CW-1:0] x_sh, y_sh;
         logic signed [CW-1:0] x_in, y_in;
         logic signed [ZW-1:0] z_in;

         // One micro-rotation, direction from the sign of the residual angle.
         always_comb begin
            x_sh = x_ff[s][l] >>> s;
            y_sh = y_ff[s][l] >>> s;
            if (!z_ff[s][l][ZW-1]) begin
               x_in = x_ff[s][l] - y_sh;
               y_in = y_ff[s][l] + x_sh;
               z_in = z_ff[s][l] - ang_entry(s);
            end else begin
               x_in = x_ff[s][l] + y_sh;
               y_in = y_ff[s][l] - x_sh;
               z_in = z_ff[s][l] + ang_entry(s);
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               x_ff[s+1][l] <= x_in;
               y_ff[s+1][l] <= y_in;
               z_ff[s+1][l] <= z_in;
               q_ff[s+1][l] <= q_ff[s][l];
            end
         end
      end
   end

   for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_unfold
      logic signed [CW-1:0] cos_in, sin_in;

      // Put the folded quadrant back.
      always_comb begin
         case (q_ff[ITER][l])
            QUAD_0: begin
               cos_in = x_ff[ITER][l];
               sin_in = y_ff[ITER][l];
            end
            QUAD_90: begin
               cos_in = -y_ff[ITER][l];
               sin_in = x_ff[ITER][l];
            end
            QUAD_180: begin
               cos_in = -x_ff[ITER][l];
               sin_in = -y_ff[ITER][l];
            end
            default: begin
               cos_in = y_ff[ITER][l];
               sin_in = -x_ff[ITER][l];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cos_out[l] <= cos_in;
            sin_out[l] <= sin_in;
         end
      end
   end

endmodule

FILE: rtl/hvd_isqrt.sv
// Pipelined digit-recurrence floor square root, one result bit per stage.
module hvd_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [hvd_pkg::SQ_W-1:0]      in_value [hvd_pkg::SQRT_LANES],
   output logic                          out_valid,
   output logic [hvd_pkg::ROOT_W-1:0]    out_root [hvd_pkg::SQRT_LANES]
);
   import hvd_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [SQ_W-1:0]       rem_ff [SQRT_STEPS][SQRT_LANES];
   logic [SQ_W-1:0]       res_ff [SQRT_STEPS][SQRT_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));

      for (genvar l = 0; l < SQRT_LANES; l++) begin : g_lane
         logic [SQ_W-1:0] rem_src, res_src;
         logic [SQ_W-1:0] trial;
         logic [SQ_W-1:0] rem_in, res_in;

         if (k == 0) begin : g_first
            assign rem_src = in_value[l];
            assign res_src = '0;
         end else begin : g_next
            assign rem_src = rem_ff[k-1][l];
            assign res_src = res_ff[k-1][l];
         end

         // Keep the trial bit when the remainder covers it.
         always_comb begin
            trial = res_src + STEP_BIT;
            if (rem_src >= trial) begin
               rem_in = rem_src - trial;
               res_in = (res_src >> 1) + STEP_BIT;
            end else begin
               rem_in = rem_src;
               res_in = res_src >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][l] <= rem_in;
               res_ff[k][l] <= res_in;
            end
         end
      end
   end

   for (genvar l = 0; l < SQRT_LANES; l++) begin : g_out
      assign out_root[l] = res_ff[SQRT_STEPS-1][l][ROOT_W-1:0];
   end

endmodule

FILE: rtl/hvd_vector.sv
// Pipelined CORDIC vectoring giving the angle of a vector, clamped to 90 degrees.
module hvd_vector #(
   parameter int ITER = hvd_pkg::CORDIC_ITER_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [hvd_pkg::ROOT_W-1:0]  in_x,
   input  logic [hvd_pkg::ROOT_W-1:0]  in_y,
   output logic                        out_valid,
   output logic [hvd_pkg::ROOT_W-1:0]  out_angle
);
   import hvd_pkg::*;

   localparam logic signed [ZW-1:0] ANGLE_MAX = ZW'(1) << 30;

   logic [ITER:0]        valid_ff;
   logic signed [CW-1:0] x_ff [ITER];
   logic signed [CW-1:0] y_ff [ITER];
   logic signed [ZW-1:0] z_ff [ITER];
   logic [ROOT_W-1:0]    angle_in, angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ITER-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[ITER];

   for (genvar s = 0; s < ITER; s++) begin : g_iter
      logic signed [CW-1:0] x_src, y_src;
      logic signed [ZW-1:0] z_src;
      logic signed [CW-1:0] x_sh, y_sh;
      logic signed [CW-1:0] x_in, y_in;
      logic signed [ZW-1:0] z_in;

      if (s == 0) begin : g_first
         assign x_src = CW'(signed'({1'b0, in_x}));
         assign y_src = CW'(signed'({1'b0, in_y}));
         assign z_src = '0;
      end else begin : g_next
         assign x_src = x_ff[s-1];
         assign y_src = y_ff[s-1];
         assign z_src = z_ff[s-1];
      end

      // Rotate toward the x axis and accumulate the angle turned.
      always_comb begin
         x_sh = x_src >>> s;
         y_sh = y_src >>> s;
         if (y_src > 0) begin
            x_in = x_src + y_sh;
            y_in = y_src - x_sh;
            z_in = z_src + ang_entry(s);
         end else begin
            x_in = x_src - y_sh;
            y_in = y_src + x_sh;
            z_in = z_src - ang_entry(s);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[s] <= x_in;
            y_ff[s] <= y_in;
            z_ff[s] <= z_in;
         end
      end
   end

   // Clamp the angle to the range from zero to a quarter turn.
   always_comb begin
      if (z_ff[ITER-1][ZW-1]) begin
         angle_in = '0;
      end else if (z_ff[ITER-1] > ANGLE_MAX) begin
         angle_in = ROOT_W'(ANGLE_MAX);
      end else begin
         angle_in = z_ff[ITER-1][ROOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign out_angle = angle_ff;

endmodule

FILE: rtl/haversine_distance.sv
// Top level of the haversine great-circle distance pipeline.
//
// Each item on req_chan carries two positions (latitude and longitude in
// signed units of 1e-7 degree). Each item gives exactly one item on rsp_chan:
// the great-circle distance in millimetres, saturated at 22000000000.
// The sphere radius in metres is written through csr_wr_en / csr_wr_data
// and resets to 6371000; write it only while no item is in flight.
//
// Throughput is one item per cycle while rsp_chan takes results. An item passes
// 2*CORDIC_ITERATIONS + 51 register stages (115 at the default of 32): input
// register, angle conversion, CORDIC rotation, the haversine products, a 32-step
// square root, CORDIC vectoring, distance scaling and the output register.
//
// Reset empties the pipeline; items in flight are dropped. A two-entry output
// buffer (output register plus skid register) sits at the end: while rsp_chan
// stalls, one more item moves into the skid register, then the whole pipeline
// holds and req_chan.ready falls until the skid register drains.
`include "haversine_distance_macros.svh"

module haversine_distance #(
   parameter int CORDIC_ITERATIONS = hvd_pkg::CORDIC_ITER_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   hvd_req_if.sink                       req_chan,
   hvd_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [hvd_pkg::RADIUS_W-1:0]  csr_wr_data
);
   import hvd_pkg::*;

   localparam int M_STAGES = 5;
   localparam int D_STAGES = 5;

   logic pipe_adv;

   // Radius register.
   logic [RADIUS_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // Input register: the four angles that need trig values.
   logic                     in_valid_ff;
   logic signed [DIFF_W-1:0] ang_in [NUM_ANGLES];
   logic signed [DIFF_W-1:0] ang_ff [NUM_ANGLES];

   assign req_chan.ready = pipe_adv;

   always_comb begin
      ang_in[0] = DIFF_W'(req_chan.first_lat);
      ang_in[1] = DIFF_W'(req_chan.second_lat);
      ang_in[2] = DIFF_W'(req_chan.second_lat) - DIFF_W'(req_chan.first_lat);
      ang_in[3] = DIFF_W'(req_chan.second_lon) - DIFF_W'(req_chan.first_lon);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         ang_ff <= ang_in;
      end
   end

   // Binary angles and their cosines and sines.
   logic                 bam_valid;
   logic [ANG_W-1:0]     bam [NUM_ANGLES];
   logic                 rot_valid;
   logic signed [CW-1:0] rot_cos [NUM_ANGLES];
   logic signed [CW-1:0] rot_sin [NUM_ANGLES];

   hvd_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_adv),
      .in_valid  (in_valid_ff),
      .in_angle  (ang_ff),
      .out_valid (bam_valid),
      .out_bam   (bam)
   );

   hvd_rotate #(
      .ITER (CORDIC_ITERATIONS)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_adv),
      .in_valid  (bam_valid),
      .in_bam    (bam),
      .out_valid (rot_valid),
      .cos_out   (rot_cos),
      .sin_out   (rot_sin)
   );

   // Haversine term a = s1^2 + ((c1 c2) s2) s2 in Q60, with each product registered.
   logic [M_STAGES-1:0]      m_valid_ff;
   logic signed [PROD_W-1:0] cc_in, cc_ff;
   logic signed [PROD_W-1:0] s1sq1_in, s1sq1_ff, s1sq2_ff, s1sq3_ff;
   logic signed [CW-1:0]     s2a_ff, s2b_ff;
   logic signed [CW-1:0]     t30;
   logic signed [PROD_W-1:0] pr_in, pr_ff;
   logic signed [CW-1:0]     tt;
   logic signed [PROD_W-1:0] term_in, term_ff;
   logic signed [PROD_W:0]   a_sum;
   logic [A_W-1:0]           a60_in, a60_ff;
   logic [SQ_W-1:0]          root_arg_in [SQRT_LANES];
   logic [SQ_W-1:0]          root_arg_ff [SQRT_LANES];

   always_comb begin
      cc_in    = PROD_W'(rot_cos[0]) * PROD_W'(rot_cos[1]);
      s1sq1_in = PROD_W'(rot_sin[2]) * PROD_W'(rot_sin[2]);
      t30      = CW'(cc_ff >>> 30);
      pr_in    = PROD_W'(t30) * PROD_W'(s2a_ff);
      tt       = CW'(pr_ff >>> 30);
      term_in  = PROD_W'(tt) * PROD_W'(s2b_ff);
      // Clamp a to the range from zero to one.
      a_sum    = (PROD_W + 1)'(s1sq3_ff) + (PROD_W + 1)'(term_ff);
      if (a_sum[PROD_W]) begin
         a60_in = '0;
      end else if (a_sum > (PROD_W + 1)'(ONE_Q60)) begin
         a60_in = A_W'(ONE_Q60);
      end else begin
         a60_in = a_sum[A_W-1:0];
      end
      root_arg_in[0] = SQ_W'(a60_ff);
      root_arg_in[1] = ONE_Q60 - SQ_W'(a60_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= '0;
      end else if (pipe_adv) begin
         m_valid_ff <= {m_valid_ff[M_STAGES-2:0], rot_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         cc_ff       <= cc_in;
         s1sq1_ff    <= s1sq1_in;
         s2a_ff      <= rot_sin[3];
         pr_ff       <= pr_in;
         s1sq2_ff    <= s1sq1_ff;
         s2b_ff      <= s2a_ff;
         term_ff     <= term_in;
         s1sq3_ff    <= s1sq2_ff;
         a60_ff      <= a60_in;
         root_arg_ff <= root_arg_in;
      end
   end

   // Square roots of a and 1 - a, then the angle between them.
   logic              root_valid;
   logic [ROOT_W-1:0] roots [SQRT_LANES];
   logic              vec_valid;
   logic [ROOT_W-1:0] half_angle;

   hvd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_adv),
      .in_valid  (m_valid_ff[M_STAGES-1]),
      .in_value  (root_arg_ff),
      .out_valid (root_valid),
      .out_root  (roots)
   );

   hvd_vector #(
      .ITER (CORDIC_ITERATIONS)
   ) u_vector (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_adv),
      .in_valid  (root_valid),
      .in_x      (roots[1]),
      .in_y      (roots[0]),
      .out_valid (vec_valid),
      .out_angle (half_angle)
   );

   // Distance: angle to Q30 radians, times radius, metres to millimetres.
   logic [D_STAGES-1:0] d_valid_ff;
   logic [CQP_W-1:0]    cqp_in, cqp_ff;
   logic [CQP_W-1:0]    cq_sum;
   logic [CQ_W-1:0]     cq_in, cq_ff;
   logic [P_W-1:0]      p_in, p_ff;
   logic [DIST_W-1:0]   hi_in, hi_ff;
   logic [LO_W-1:0]     lo_sum;
   logic [9:0]          lo_in, lo_ff;
   logic [DIST_W:0]     dist_sum;
   logic [DIST_W-1:0]   dist_in, dist_ff;

   always_comb begin
      cqp_in   = CQP_W'(half_angle) * CQP_W'(PI_Q30);
      cq_sum   = cqp_ff + (CQP_W'(1) << 29);
      cq_in    = cq_sum[61:30];
      p_in     = P_W'(radius_ff) * P_W'(cq_ff);
      hi_in    = DIST_W'(p_ff[P_W-1:30]) * DIST_W'(MM_PER_M);
      lo_sum   = LO_W'(p_ff[29:0]) * LO_W'(MM_PER_M) + (LO_W'(1) << 29);
      lo_in    = lo_sum[LO_W-1:30];
      dist_sum = (DIST_W + 1)'(hi_ff) + (DIST_W + 1)'(lo_ff);
      if (dist_sum > (DIST_W + 1)'(DIST_MAX)) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = dist_sum[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= '0;
      end else if (pipe_adv) begin
         d_valid_ff <= {d_valid_ff[D_STAGES-2:0], vec_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         cqp_ff  <= cqp_in;
         cq_ff   <= cq_in;
         p_ff    <= p_in;
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         dist_ff <= dist_in;
      end
   end

   // Output register with a skid register behind it.
   logic              last_valid;
   logic              out_valid_in, out_valid_ff;
   logic [DIST_W-1:0] out_data_in, out_data_ff;
   logic              skid_valid_in, skid_valid_ff;
   logic [DIST_W-1:0] skid_data_in, skid_data_ff;

   assign last_valid = d_valid_ff[D_STAGES-1];
   assign pipe_adv   = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = last_valid;
            out_data_in  = dist_ff;
         end
      end else if (last_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.distance_mm = out_data_ff;

   // The skid register only fills behind a waiting output item.
   `HVD_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // A taken output item drains the skid register.
   `HVD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && rsp_chan.ready, !skid_valid_ff)
   // A held pipeline keeps its last stage.
   `HVD_ASSERT_NEXT(a_pipe_holds, clock, reset, !pipe_adv && last_valid, last_valid && $stable(dist_ff))
   // Results never exceed the saturation limit.
   `HVD_ASSERT_IMP(a_dist_bound, clock, reset, out_valid_ff, out_data_ff <= DIST_MAX)

endmodule

FILE: tb/hvd_tb_pkg.sv
// Package with the distance predictor used by the checker of the haversine block.
package hvd_tb_pkg;
   import hvd_pkg::*;

   // Arctangent step for CORDIC index i in binary-angle units.
   function automatic longint atan_step(input int i);
      if (i < ANG_TABLE_LEN) begin
         return longint'(ANG_TABLE[i]);
      end
      return 0;
   endfunction

   // Arithmetic shift right that rounds toward minus infinity.
   function automatic longint shr_floor(input longint v, input int s);
      return v >>> s;
   endfunction

   // Converts an angle in 1e-7 degree to a binary angle, full or half.
   function automatic logic [31:0] deg_to_bam(input longint x, input int shift);
      logic [63:0] u;
      logic [63:0] p;
      logic [31:0] r;
      u = (x < 0) ? 64'(-x) : 64'(x);
      u = u % 64'd3600000000;
      p = u * 64'd1281023894;
      r = 32'((p + (64'd1 << (shift - 1))) >> shift);
      if (x < 0) begin
         r = 32'd0 - r;
      end
      return r;
   endfunction

   // CORDIC rotation giving cosine and sine in Q2.30.
   function automatic void rotate_sincos(input logic [31:0] a, input int iters,
                                         output longint c, output longint s);
      logic [1:0] q;
      logic [31:0] rr;
      longint z, x, y, nx;
      q = 2'(((a + 32'h20000000) >> 30) & 32'd3);
      rr = a - (32'(q) << 30);
      z = longint'(signed'(rr));
      x = 652032874;
      y = 0;
      for (int i = 0; i < iters; i++) begin
         if (z >= 0) begin
            nx = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            z -= atan_step(i);
         end else begin
            nx = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            z += atan_step(i);
         end
         x = nx;
      end
      case (quad_type'(q))
         QUAD_0: begin c = x; s = y; end
         QUAD_90: begin c = -y; s = x; end
         QUAD_180: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Floor square root by digit recurrence.
   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [63:0] rem, res, bitv;
      rem = n;
      res = 0;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= res + bitv) begin
            rem -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // CORDIC vectoring giving the angle of (x, y), clamped to a quarter turn.
   function automatic longint vector_angle(input longint x, input longint y,
                                           input int iters);
      longint z, nx;
      z = 0;
      for (int i = 0; i < iters; i++) begin
         if (y > 0) begin
            nx = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            z += atan_step(i);
         end else begin
            nx = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            z -= atan_step(i);
         end
         x = nx;
      end
      if (z < 0) z = 0;
      if (z > (longint'(1) << 30)) z = longint'(1) << 30;
      return z;
   endfunction

   // Great-circle distance in millimetres for one pair of positions.
   function automatic logic [DIST_W-1:0] predict_distance(
         input logic signed [LAT_W-1:0] lat1, input logic signed [LON_W-1:0] lon1,
         input logic signed [LAT_W-1:0] lat2, input logic signed [LON_W-1:0] lon2,
         input logic [RADIUS_W-1:0] radius, input int iters);
      longint c1, c2, s1, s2, dummy, t30, term, a60, z;
      logic [63:0] sa, ca, cq, p, dist_mm;
      rotate_sincos(deg_to_bam(longint'(lat1), 30), iters, c1, dummy);
      rotate_sincos(deg_to_bam(longint'(lat2), 30), iters, c2, dummy);
      rotate_sincos(deg_to_bam(longint'(lat2) - longint'(lat1), 31), iters, dummy, s1);
      rotate_sincos(deg_to_bam(longint'(lon2) - longint'(lon1), 31), iters, dummy, s2);
      t30 = shr_floor(c1 * c2, 30);
      term = shr_floor(t30 * s2, 30) * s2;
      a60 = s1 * s1 + term;
      if (a60 < 0) a60 = 0;
      if (a60 > (longint'(1) << 60)) a60 = longint'(1) << 60;
      sa = floor_root(64'(a60));
      ca = floor_root((64'd1 << 60) - 64'(a60));
      z = vector_angle(longint'(ca), longint'(sa), iters);
      cq = (64'(z) * 64'd3373259426 + (64'd1 << 29)) >> 30;
      p = 64'(radius) * cq;
      dist_mm = (p >> 30) * 64'd1000 + (((p & ((64'd1 << 30) - 1)) * 64'd1000
                + (64'd1 << 29)) >> 30);
      if (dist_mm > 64'd22000000000) dist_mm = 64'd22000000000;
      return DIST_W'(dist_mm);
   endfunction
endpackage

FILE: tb/hvd_checker.sv
// Checker that predicts each distance and compares it with the result channel.
module hvd_checker #(
   parameter int ITERS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   hvd_req_if.sink                       req_mon,
   hvd_rsp_if.sink                       rsp_mon,
   input  logic                          csr_wr_en,
   input  logic [hvd_pkg::RADIUS_W-1:0]  csr_wr_data,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hvd_pkg::*;
   import hvd_tb_pkg::*;

   logic [RADIUS_W-1:0] radius_m;
   logic [DIST_W-1:0]   expected_distances [$];
   logic [DIST_W-1:0]   want;

   // Track the radius, queue a prediction per accepted item, compare results.
   always @(posedge clock) begin
      if (reset) begin
         radius_m <= RADIUS_RESET;
         expected_distances.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            radius_m <= csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_distances.push_back(predict_distance(req_mon.first_lat,
               req_mon.first_lon, req_mon.second_lat, req_mon.second_lon,
               radius_m, ITERS));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: unexpected distance_mm %0d", $time, rsp_mon.distance_mm);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_distances.pop_front();
               if (want !== rsp_mon.distance_mm) begin
                  $display("%0t: distance_mm expected %0d actual %0d", $time, want,
                           rsp_mon.distance_mm);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_distances.size();
      end
   end
endmodule

FILE: tb/testbench.sv
// Top of the haversine distance testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hvd_pkg::*;

   localparam int ITEMS = 1300;
   localparam int LATENCY = 2 * CORDIC_ITER_DEF + 51;
   localparam longint LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [RADIUS_W-1:0] csr_wr_data = '0;
   int fail_count, pending_count;
   longint cycle_count = 0;
   bit quiet = 0;
   bit hold_off = 0;

   hvd_req_if req_chan ();
   hvd_rsp_if rsp_chan ();

   haversine_distance DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   hvd_checker #(.ITERS(CORDIC_ITER_DEF)) distance_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold-off, none at the end.
   initial begin
      int burst;
      rsp_chan.ready <= 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_chan.ready <= 0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1;
            @(posedge clock);
         end
      end
   end

   // Sends one item, with an optional random idle burst before it.
   task automatic send_pair(input logic signed [LAT_W-1:0] lat1,
                            input logic signed [LON_W-1:0] lon1,
                            input logic signed [LAT_W-1:0] lat2,
                            input logic signed [LON_W-1:0] lon2);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.first_lat <= lat1;
      req_chan.first_lon <= lon1;
      req_chan.second_lat <= lat2;
      req_chan.second_lon <= lon2;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Random well-ranged latitude or longitude, sometimes a raw bit pattern.
   function automatic logic signed [LAT_W-1:0] rand_lat();
      if ($urandom_range(0, 9) == 0) return LAT_W'($urandom);
      return LAT_W'(int'($urandom_range(0, 1800000000)) - 900000000);
   endfunction

   function automatic logic signed [LON_W-1:0] rand_lon();
      if ($urandom_range(0, 9) == 0) return LON_W'($urandom);
      return LON_W'(longint'($urandom_range(0, 3600000000)) - 64'sd1800000000);
   endfunction

   // Waits until every distance has come back, then lets the pipeline drain.
   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_radius(input logic [RADIUS_W-1:0] r);
      csr_wr_en <= 1;
      csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // Stimulus.
   initial begin
      logic [RADIUS_W-1:0] radii [5];
      radii = '{23'd6000000, 23'd7000000, 23'd0, 23'h7FFFFF, 23'd6371000};
      req_chan.valid <= 0;
      req_chan.first_lat <= '0;
      req_chan.first_lon <= '0;
      req_chan.second_lat <= '0;
      req_chan.second_lon <= '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: identical points, poles, antipodes, date line, raw extremes.
      send_pair(0, 0, 0, 0);
      send_pair(900000000, 0, -900000000, 0);
      send_pair(0, 0, 0, 1800000000);
      send_pair(0, -1800000000, 0, 1800000000);
      send_pair(0, 1799999999, 0, -1799999999);
      send_pair(900000000, 1800000000, 900000000, -1800000000);
      send_pair(-900000000, -1800000000, 900000000, 1800000000);
      send_pair(31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000);
      send_pair(31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF);
      send_pair(-1, -1, 1, 1);
      send_pair(515000000, -1200000, 407000000, -740000000);
      send_pair(0, 0, 1, 0);
      drain();

      // Random phases across radius settings, with a long stall in the first.
      for (int ph = 0; ph < 5; ph++) begin
         set_radius(radii[ph]);
         if (ph == 4) quiet = 1;
         for (int n = 0; n < ITEMS / 5; n++) begin
            if (ph == 0 && n == 20) hold_off = 1;
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
